@@ sv/plic_pkg.sv @@
// shared types and constants for the positional list
`default_nettype none

package plic_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int ELEM_W     = 32;
    localparam int POS_W      = 5;
    localparam int LEN_W      = 5;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [1:0] FUNC_LOCATE = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               func;
        logic [POS_W-1:0]         position;
        logic signed [ELEM_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic                     found;
        logic [POS_W-1:0]         found_position;
        logic signed [ELEM_W-1:0] removed_value;
        logic [LEN_W-1:0]         length;
    } rsp_t;

    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  cnt;
        logic [ELEM_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/plic_cell.sv @@
// one list slot: holds an element, compares it and shifts with its neighbors
`default_nettype none

module plic_cell
    import plic_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [CMP_W-1:0]  slot,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [ELEM_W-1:0] left_data,
    input  wire logic [ELEM_W-1:0] right_data,
    output logic      [ELEM_W-1:0] data,
    output logic                   match,
    output logic      [ELEM_W-1:0] pick
);

    logic [ELEM_W-1:0] data_reg;
    logic [ELEM_W-1:0] data_next;
    logic              at_pos;

    assign at_pos = (slot == ctrl.pos);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (at_pos)
            begin
                data_next = ctrl.value;
            end
            else if ((slot > ctrl.pos) && (slot <= ctrl.cnt + CMP_W'(1)))
            begin
                data_next = left_data;
            end
        end
        else if (ctrl.del_en)
        begin
            if ((slot >= ctrl.pos) && (slot < ctrl.cnt))
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (slot <= ctrl.cnt) && (data_reg == ctrl.value);
    assign pick  = at_pos ? data_reg : '0;

endmodule

`default_nettype wire

@@ sv/positional_list_insert_delete_locate.sv @@
// Positional list with locate, insert and delete held in a row of slot cells.
// Requests enter on req/req_valid and are taken when req_stall is low; each
// word carries func, a 1-based position and a signed value. Results leave on
// rsp/rsp_valid and are taken when rsp_stall is low, one result word per
// request, in request order.
// Locate reports the first matching position, insert writes at a position and
// moves later entries up, delete returns the entry at a position and moves
// later entries down. Bad positions give a range status, insert into a full
// list gives a full status, and in both cases the list stays as it was.
// One request is in flight at a time. The request register captures it, then
// in the execute state all cells compare and shift together, then the finish
// state encodes the first match into the result register, waiting there while
// the output register is still full.
// Reset empties the list. A stalled result stays in its register; the block
// still takes one new request meanwhile and holds its own result until the
// output register frees up.
`default_nettype none

module positional_list_insert_delete_locate
    import plic_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    req_t                  req_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [LIST_DEPTH-1:0] match_reg;
    logic [ELEM_W-1:0]     removed_reg;
    logic [1:0]            status_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic [CMP_W-1:0]      pos_c, cnt_c;
    logic                  ins_ok, del_ok;
    logic [1:0]            status_c;
    cell_ctrl_t            ctrl;
    logic                  out_free;

    logic [ELEM_W-1:0]     cell_data [LIST_DEPTH];
    logic [ELEM_W-1:0]     cell_pick [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_match;
    logic [ELEM_W-1:0]     pick_or;

    logic                  enc_found;
    logic [POS_W-1:0]      enc_pos;

    assign pos_c = CMP_W'(req_reg.position);
    assign cnt_c = CMP_W'(count_reg);

    always_comb
    begin
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        status_c = STATUS_OK;
        unique case (req_reg.func)
            FUNC_INSERT:
            begin
                if (cnt_c >= CMP_W'(LIST_DEPTH))
                begin
                    status_c = STATUS_FULL;
                end
                else if ((pos_c == '0) || (pos_c > cnt_c + CMP_W'(1)))
                begin
                    status_c = STATUS_RANGE;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            FUNC_DELETE:
            begin
                if ((pos_c == '0) || (pos_c > cnt_c))
                begin
                    status_c = STATUS_RANGE;
                end
                else
                begin
                    del_ok = 1'b1;
                end
            end
            default:
            begin
                status_c = STATUS_OK;
            end
        endcase
    end

    assign ctrl.ins_en = (state_reg == S_EXEC) && ins_ok;
    assign ctrl.del_en = (state_reg == S_EXEC) && del_ok;
    assign ctrl.pos    = pos_c;
    assign ctrl.cnt    = cnt_c;
    assign ctrl.value  = req_reg.value;

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [ELEM_W-1:0] left_d, right_d;
        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end
        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end
        plic_cell u_cell (
            .clk        (clk),
            .slot       (CMP_W'(i + 1)),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (cell_match[i]),
            .pick       (cell_pick[i])
        );
    end

    always_comb
    begin
        pick_or = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            pick_or = pick_or | cell_pick[i];
        end
    end

    // first match: lowest set bit of the registered match vector
    always_comb
    begin
        enc_found = 1'b0;
        enc_pos   = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                enc_found = 1'b1;
                enc_pos   = POS_W'(i + 1);
            end
        end
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                if (ins_ok)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (del_ok)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if ((state_reg == S_FIN) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            req_reg <= req;
        end
        if (state_reg == S_EXEC)
        begin
            match_reg   <= (req_reg.func == FUNC_LOCATE) ? cell_match : '0;
            removed_reg <= del_ok ? pick_or : '0;
            status_reg  <= status_c;
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            rsp_reg.status         <= status_reg;
            rsp_reg.found          <= enc_found;
            rsp_reg.found_position <= enc_pos;
            rsp_reg.removed_value  <= removed_reg;
            rsp_reg.length         <= LEN_W'(count_reg);
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count beyond depth");

    a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(count_reg))
        else $error("list count moved outside execute");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result word without a finished request");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.found) |-> (rsp_reg.status == STATUS_OK))
        else $error("match reported with error status");

    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.removed_value != '0))
            |-> (rsp_reg.status == STATUS_OK) && !rsp_reg.found)
        else $error("removed word on a failed or locate request");

endmodule

`default_nettype wire

@@ dv/plic_list_checker.sv @@
// checker for the positional list: predicts each result word and compares it on arrival
module plic_list_checker
    import plic_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending
);

    logic signed [ELEM_W-1:0] list_mem [LIST_DEPTH];
    int                       list_len;
    rsp_t                     rsp_expected_q [$];

    task automatic predict_rsp(input req_t r, output rsp_t e);
        int k;
        int pos;
        e = '0;
        e.status = STATUS_OK;
        pos = int'(r.position);
        case (r.func)
            FUNC_LOCATE:
            begin
                for (k = 0; k < list_len; k++)
                begin
                    if (!e.found && list_mem[k] == r.value)
                    begin
                        e.found = 1'b1;
                        e.found_position = POS_W'(k + 1);
                    end
                end
            end
            FUNC_INSERT:
            begin
                if (list_len >= LIST_DEPTH)
                    e.status = STATUS_FULL;
                else if (pos < 1 || pos > list_len + 1)
                    e.status = STATUS_RANGE;
                else
                begin
                    for (k = list_len; k >= pos; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pos-1] = r.value;
                    list_len++;
                end
            end
            FUNC_DELETE:
            begin
                if (pos < 1 || pos > list_len)
                    e.status = STATUS_RANGE;
                else
                begin
                    e.removed_value = list_mem[pos-1];
                    for (k = pos; k < list_len; k++)
                        list_mem[k-1] = list_mem[k];
                    list_len--;
                end
            end
            default:
            begin
            end
        endcase
        e.length = LEN_W'(list_len);
    endtask

    always @(posedge clk)
    begin
        rsp_t e;
        if (!rst_n)
        begin
            list_len = 0;
            fail_count = 0;
            pending = 0;
            rsp_expected_q.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display(
                            "%0t chk: unexpected word st %0d fnd %0d fpos %0d rem %0d len %0d",
                            $time, rsp.status, rsp.found, rsp.found_position,
                            rsp.removed_value, rsp.length);
                end
                else
                begin
                    e = rsp_expected_q.pop_front();
                    if (rsp.status !== e.status || rsp.found !== e.found ||
                        rsp.found_position !== e.found_position ||
                        rsp.removed_value !== e.removed_value || rsp.length !== e.length)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display(
                                "%0t chk: mismatch exp st %0d fnd %0d fpos %0d rem %0d len %0d",
                                $time, e.status, e.found, e.found_position,
                                e.removed_value, e.length);
                            $display(
                                "%0t chk: mismatch act st %0d fnd %0d fpos %0d rem %0d len %0d",
                                $time, rsp.status, rsp.found, rsp.found_position,
                                rsp.removed_value, rsp.length);
                        end
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_rsp(req, e);
                rsp_expected_q.push_back(e);
            end
            pending = rsp_expected_q.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// testbench top for the positional list: stimulus, receiver stalls, watchdog and verdict
module tb;
    import plic_pkg::*;

    localparam logic [1:0] FUNC_NONE    = 2'd3;
    localparam int         N_RANDOM     = 800;
    localparam int         IDLE_LIMIT   = 3000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_START   = 1000;
    localparam int         HOLD_END     = 1400;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    int   stim_len;
    int   burst_left;

    always #5 clk = ~clk;

    positional_list_insert_delete_locate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    plic_list_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic req_t make_req(input logic [1:0] f, input int p,
                                      input logic signed [ELEM_W-1:0] v);
        req_t w;
        w.func     = f;
        w.position = p[POS_W-1:0];
        w.value    = v;
        return w;
    endfunction

    // offer one word, hold it until taken, then maybe end the burst with a gap
    task automatic push_req(input req_t w);
        int p;
        int gap;
        p = int'(w.position);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (w.func == FUNC_INSERT && stim_len < LIST_DEPTH && p >= 1 && p <= stim_len + 1)
            stim_len++;
        else if (w.func == FUNC_DELETE && p >= 1 && p <= stim_len)
            stim_len--;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin : receiver
        int cyc;
        int mode;
        int seg;
        rsp_stall <= 1'b0;
        cyc = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(16, 96);
            repeat (seg)
            begin
                @(posedge clk);
                cyc++;
                // long hold-off so the block backs up and stalls its input
                if (cyc >= HOLD_START && cyc < HOLD_END)
                    rsp_stall <= 1'b1;
                else
                    case (mode)
                        0: rsp_stall <= 1'b0;
                        1: rsp_stall <= ($urandom_range(0, 3) == 0);
                        2: rsp_stall <= ($urandom_range(0, 9) < 6);
                        default: rsp_stall <= cyc[2];
                    endcase
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle = 0;
            else
                idle++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int                       i;
        int                       p;
        int                       pick;
        int                       vsel;
        logic [1:0]               f;
        logic signed [ELEM_W-1:0] v;
        logic signed [ELEM_W-1:0] seed_vals [4];
        seed_vals[0] = 32'sh7fffffff;
        seed_vals[1] = 32'sh80000000;
        seed_vals[2] = 32'sd0;
        seed_vals[3] = -32'sd1;
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req        <= '0;
        stim_len   = 0;
        burst_left = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list cases
        push_req(make_req(FUNC_LOCATE, 0, 32'sd0));
        push_req(make_req(FUNC_DELETE, 1, 32'sd0));
        push_req(make_req(FUNC_INSERT, 0, 32'sd5));
        push_req(make_req(FUNC_INSERT, 2, 32'sd5));
        push_req(make_req(FUNC_NONE, 31, -32'sd1));
        // fill at front, end and middle
        for (i = 0; i < LIST_DEPTH; i++)
        begin
            p = (i % 3 == 0) ? 1 : ((i % 3 == 1) ? i + 1 : i / 2 + 1);
            v = (i < 4) ? seed_vals[i] : ((i % 2) ? 32'sd7 : $urandom);
            push_req(make_req(FUNC_INSERT, p, v));
        end
        // full list, duplicates, edge positions
        push_req(make_req(FUNC_INSERT, 31, 32'sd9));
        push_req(make_req(FUNC_LOCATE, 0, 32'sd7));
        push_req(make_req(FUNC_LOCATE, 17, 32'sd12345));
        push_req(make_req(FUNC_DELETE, 17, 32'sd0));
        push_req(make_req(FUNC_DELETE, 16, 32'sd0));
        push_req(make_req(FUNC_DELETE, 1, 32'sd0));
        push_req(make_req(FUNC_LOCATE, 31, 32'sh80000000));

        for (i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(0, 99);
            // alternate fill-heavy and drain-heavy stretches
            if ((i / 100) % 2 == 0)
                f = (pick < 50) ? FUNC_INSERT : (pick < 75) ? FUNC_LOCATE :
                    (pick < 95) ? FUNC_DELETE : FUNC_NONE;
            else
                f = (pick < 20) ? FUNC_INSERT : (pick < 50) ? FUNC_LOCATE :
                    (pick < 95) ? FUNC_DELETE : FUNC_NONE;
            if ($urandom_range(0, 9) < 8)
            begin
                if (f == FUNC_DELETE)
                    p = (stim_len > 0) ? $urandom_range(1, stim_len) : 1;
                else
                    p = $urandom_range(1, stim_len + 1);
            end
            else
                p = $urandom_range(0, 31);
            vsel = $urandom_range(0, 9);
            if (vsel < 4)
                v = int'($urandom_range(0, 7)) - 3;
            else if (vsel == 4)
                v = 32'sh7fffffff;
            else if (vsel == 5)
                v = 32'sh80000000;
            else
                v = $urandom;
            push_req(make_req(f, p, v));
        end
        req_valid <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
